FILE: rtl/core/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the response stream deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

	// counter width of the success, error and completion counters
	localparam int COUNT_WIDTH = 48;

	// widths of the result fields as seen on the ports
	localparam int STATUS_W = 16;
	localparam int LENGTH_W = 32;
	localparam int TOTAL_W  = 48;
	localparam int FILL_W   = 5;

	localparam logic [7:0] RESP_MAGIC = 8'h81;
	localparam int HEADER_BYTES = 24;

	// header byte positions
	localparam logic [FILL_W-1:0] POS_MAGIC     = FILL_W'(0);
	localparam logic [FILL_W-1:0] POS_STATUS_HI = FILL_W'(6);
	localparam logic [FILL_W-1:0] POS_STATUS_LO = FILL_W'(7);
	localparam logic [FILL_W-1:0] POS_LEN_B3    = FILL_W'(8);
	localparam logic [FILL_W-1:0] POS_LEN_B2    = FILL_W'(9);
	localparam logic [FILL_W-1:0] POS_LEN_B1    = FILL_W'(10);
	localparam logic [FILL_W-1:0] POS_LEN_B0    = FILL_W'(11);
	localparam logic [FILL_W-1:0] POS_LAST      = FILL_W'(HEADER_BYTES - 1);

	// opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DESYNC = 2'd1,
		KIND_REPORT = 2'd2
	} result_kind_t;

	typedef struct packed {
		result_kind_t         result_kind;
		logic [STATUS_W-1:0]  status;
		logic [LENGTH_W-1:0]  body_length;
		logic                 success;
		logic [TOTAL_W-1:0]   ops_total;
		logic [TOTAL_W-1:0]   error_total;
		logic [TOTAL_W-1:0]   completed_count;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rsd_req_if.sv
// ----------------------------------------------------------------------------
// rsd_req_if
// Input channel of the deframer: one stream byte or a take request per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] stream_byte;

	modport source (output valid, output opcode, output stream_byte, input ready);
	modport sink   (input valid, input opcode, input stream_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rsd_rsp_if.sv
// ----------------------------------------------------------------------------
// rsd_rsp_if
// Result channel of the deframer: one parsed header, desync or report per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsd_rsp_if import rsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          result_kind;
	logic [STATUS_W-1:0] status;
	logic [LENGTH_W-1:0] body_length;
	logic                success;
	logic [TOTAL_W-1:0]  ops_total;
	logic [TOTAL_W-1:0]  error_total;
	logic [TOTAL_W-1:0]  completed_count;

	modport source (
		output valid, output result_kind, output status, output body_length,
		output success, output ops_total, output error_total, output completed_count,
		input ready
	);
	modport sink (
		input valid, input result_kind, input status, input body_length,
		input success, input ops_total, input error_total, input completed_count,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/response_stream_deframer.sv
// ----------------------------------------------------------------------------
// response_stream_deframer
// Parses a binary key-value response stream byte by byte and reports headers.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while req.ready is high, stream bytes and
// take requests alike. The whole parser state (header position, held
// status and length, body skip count, counters, desync flag) updates in
// the accepting cycle; its result is registered into the output buffer. A
// two-entry output buffer (output register plus skid register) lets input
// keep flowing for one result while the sink stalls; req.ready drops only
// when both entries hold results. Headers are 24 bytes with magic 0x81; the
// body that follows is skipped by count. A header with another magic emits a
// desync word and every later stream byte is dropped until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module response_stream_deframer import rsd_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	rsd_req_if.sink    req,
	rsd_rsp_if.source  rsp
);

	// parser state
	logic [FILL_W-1:0]      fill_q,      fill_nxt;
	logic [7:0]             magic_q,     magic_nxt;
	logic [STATUS_W-1:0]    status_q,    status_nxt;
	logic [LENGTH_W-1:0]    length_q,    length_nxt;
	logic [LENGTH_W-1:0]    body_left_q, body_left_nxt;
	logic [COUNT_WIDTH-1:0] ok_q,        ok_nxt;
	logic [COUNT_WIDTH-1:0] fail_q,      fail_nxt;
	logic [COUNT_WIDTH-1:0] done_q,      done_nxt;
	logic                   desync_q,    desync_nxt;

	// output buffer
	result_t out_q, skid_q, res;
	logic    out_valid_q, skid_valid_q;
	logic    has_res, accept, taken;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		logic [COUNT_WIDTH-1:0] r;
		r = (v == '1) ? v : v + COUNT_WIDTH'(1);
		return r;
	endfunction

	assign req.ready = !skid_valid_q;
	assign accept    = req.valid && req.ready;
	assign taken     = out_valid_q && rsp.ready;

	always_comb begin
		fill_nxt      = fill_q;
		magic_nxt     = magic_q;
		status_nxt    = status_q;
		length_nxt    = length_q;
		body_left_nxt = body_left_q;
		ok_nxt        = ok_q;
		fail_nxt      = fail_q;
		done_nxt      = done_q;
		desync_nxt    = desync_q;
		has_res       = 1'b0;
		res           = '0;
		res.result_kind = KIND_HEADER;

		if (req.opcode == OP_TAKE) begin
			done_nxt            = '0;
			has_res             = 1'b1;
			res.result_kind     = KIND_REPORT;
			res.completed_count = TOTAL_W'(done_q);
		end else if (!desync_q) begin
			if (body_left_q != '0) begin
				body_left_nxt = body_left_q - LENGTH_W'(1);
			end else begin
				case (fill_q)
					POS_MAGIC:     magic_nxt         = req.stream_byte;
					POS_STATUS_HI: status_nxt[15:8]  = req.stream_byte;
					POS_STATUS_LO: status_nxt[7:0]   = req.stream_byte;
					POS_LEN_B3:    length_nxt[31:24] = req.stream_byte;
					POS_LEN_B2:    length_nxt[23:16] = req.stream_byte;
					POS_LEN_B1:    length_nxt[15:8]  = req.stream_byte;
					POS_LEN_B0:    length_nxt[7:0]   = req.stream_byte;
					default: ;
				endcase
				if (fill_q == POS_LAST) begin
					fill_nxt = '0;
					has_res  = 1'b1;
					// magic, status and length were all taken by earlier bytes
					if (magic_q != RESP_MAGIC) begin
						desync_nxt      = 1'b1;
						res.result_kind = KIND_DESYNC;
					end else begin
						body_left_nxt = length_q;
						if (status_q == '0)
							ok_nxt = sat_inc(ok_q);
						else
							fail_nxt = sat_inc(fail_q);
						done_nxt        = sat_inc(done_q);
						res.status      = status_q;
						res.body_length = length_q;
						res.success     = (status_q == '0);
					end
				end else begin
					fill_nxt = fill_q + FILL_W'(1);
				end
			end
		end

		res.ops_total   = TOTAL_W'(ok_nxt);
		res.error_total = TOTAL_W'(fail_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			magic_q     <= '0;
			status_q    <= '0;
			length_q    <= '0;
			body_left_q <= '0;
			ok_q        <= '0;
			fail_q      <= '0;
			done_q      <= '0;
			desync_q    <= 1'b0;
		end else if (accept) begin
			fill_q      <= fill_nxt;
			magic_q     <= magic_nxt;
			status_q    <= status_nxt;
			length_q    <= length_nxt;
			body_left_q <= body_left_nxt;
			ok_q        <= ok_nxt;
			fail_q      <= fail_nxt;
			done_q      <= done_nxt;
			desync_q    <= desync_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// input is held off while the skid entry is full
				if (taken) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (accept && has_res) begin
				if (!out_valid_q || taken)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (taken)
				out_q <= skid_q;
		end else if (accept && has_res) begin
			if (!out_valid_q || taken)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.result_kind     = out_q.result_kind;
	assign rsp.status          = out_q.status;
	assign rsp.body_length     = out_q.body_length;
	assign rsp.success         = out_q.success;
	assign rsp.ops_total       = out_q.ops_total;
	assign rsp.error_total     = out_q.error_total;
	assign rsp.completed_count = out_q.completed_count;

endmodule

`default_nettype wire

FILE: rtl/core/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks for the response stream deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_checker import rsd_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                rsp_valid,
	input wire                rsp_ready,
	input wire [1:0]          result_kind,
	input wire [STATUS_W-1:0] status,
	input wire [LENGTH_W-1:0] body_length,
	input wire                success,
	input wire [TOTAL_W-1:0]  completed_count
);

	// a stalled result word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (result_kind == KIND_HEADER || result_kind == KIND_DESYNC ||
			result_kind == KIND_REPORT))
		else $error("unused result kind");

	// header fields only on header words
	a_non_header_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind != KIND_HEADER |->
			status == '0 && body_length == '0 && !success)
		else $error("header fields set on a non-header word");

	a_success_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind == KIND_HEADER |-> success == (status == '0))
		else $error("success does not match status");

	a_count_on_report: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind != KIND_REPORT |-> completed_count == '0)
		else $error("completion count on a non-report word");

endmodule

bind response_stream_deframer rsd_checker u_rsd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.result_kind     (rsp.result_kind),
	.status          (rsp.status),
	.body_length     (rsp.body_length),
	.success         (rsp.success),
	.completed_count (rsp.completed_count)
);

`default_nettype wire
